// File: rtl/core/u8dc_pkg.sv
`timescale 1ns / 1ps

package u8dc_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_SPACES  = 2'd1;

  localparam logic [15:0] CAPACITY_RESET = 16'd64;

  // Results one input word can cause: up to four characters, or three plus the terminator.
  localparam int MAX_RES = 4;
  localparam int NCHAR_W = $clog2(MAX_RES + 1);

  // Depth of the queue between the decoder and the output side.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef struct packed {
    logic [15:0] out_capacity;
    logic        trim;
  } u8dc_cfg_t;

  // Results that one accepted input word produced.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] chars;
    logic [NCHAR_W-1:0]      nchar;
    logic                    term;
  } u8dc_rec_t;

  // Base letters for U+0100..U+017F, first entry in the top byte.
  localparam logic [8*128-1:0] FOLD_TABLE = {
    "AaAaAa", "CcCcCcCc", "DdDd", "EeEeEeEeEe", "GgGgGgGg", "HhHh",
    "IiIiIiIiIi", "Ii", "Jj", "Kkk", "LlLlLlLlLl", "NnNnNnnNn",
    "OoOoOoOo", "RrRrRr", "SsSsSsSs", "TtTtTt", "UuUuUuUuUuUu",
    "Ww", "YyY", "ZzZzZz", "s"
  };

  // Font slot for the Latin Extended-A letters that have their own glyph, else zero.
  function automatic logic [7:0] slot_font(input logic [6:0] idx);
    logic [7:0] r;
    unique case (idx)
      7'h04: r = 8'd132;
      7'h05: r = 8'd133;
      7'h06: r = 8'd134;
      7'h07: r = 8'd135;
      7'h0C: r = 8'd136;
      7'h0D: r = 8'd137;
      7'h18: r = 8'd140;
      7'h19: r = 8'd141;
      7'h1A: r = 8'd138;
      7'h1B: r = 8'd139;
      7'h41: r = 8'd142;
      7'h42: r = 8'd143;
      7'h43: r = 8'd144;
      7'h44: r = 8'd145;
      7'h50: r = 8'd128;
      7'h51: r = 8'd129;
      7'h58: r = 8'd146;
      7'h59: r = 8'd147;
      7'h5A: r = 8'd148;
      7'h5B: r = 8'd149;
      7'h60: r = 8'd150;
      7'h61: r = 8'd151;
      7'h6E: r = 8'd152;
      7'h6F: r = 8'd153;
      7'h70: r = 8'd130;
      7'h71: r = 8'd131;
      7'h79: r = 8'd154;
      7'h7A: r = 8'd155;
      7'h7B: r = 8'd156;
      7'h7C: r = 8'd157;
      7'h7D: r = 8'd158;
      7'h7E: r = 8'd159;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Display character for a code point; zero means the code point is dropped.
  function automatic logic [7:0] map_code(input logic [20:0] cp);
    logic [7:0] r;
    logic [7:0] slot;
    r = 8'd0;
    slot = slot_font(cp[6:0]);
    if (cp[20:8] == 13'd0 && cp[7:0] >= 8'hA0) begin
      r = cp[7:0];
    end else if (cp[20:7] == 14'd2) begin
      if (slot != 8'd0) begin
        r = slot;
      end else begin
        r = FOLD_TABLE[{~cp[6:0], 3'b000} +: 8];
      end
    end else if (cp[20:2] == 19'h86) begin
      unique case (cp[1:0])
        2'd0: r = "S";
        2'd1: r = "s";
        2'd2: r = "T";
        default: r = "t";
      endcase
    end
    return r;
  endfunction

endpackage

// File: rtl/core/u8dc_front.sv
`timescale 1ns / 1ps

module u8dc_front
  import u8dc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  u8dc_cfg_t  cfg,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       q_full,
  output logic       push,
  output u8dc_rec_t  rec
);

  logic [7:0]  lead_byte, lead_byte_next;
  logic [7:0]  cont0, cont0_next;
  logic [7:0]  cont1, cont1_next;
  logic [1:0]  bytes_needed, bytes_needed_next;
  logic [1:0]  bytes_seen, bytes_seen_next;
  logic [20:0] code_accum, code_accum_next;
  logic [15:0] emitted_count, emitted_count_next;
  logic        seen_nonspace, seen_nonspace_next;

  logic                    accept;
  logic [15:0]             cap_lim;
  logic [15:0]             room16;
  logic [2:0]              room3;
  logic [MAX_RES-1:0][7:0] cb;
  logic [2:0]              cn;
  logic [2:0]              fn;
  logic [2:0]              na;
  logic                    term;
  logic                    do_fresh;
  logic [1:0]              pos;
  logic [20:0]             acc_shift;
  logic [7:0]              mapped;
  logic [2:0]              k;
  logic                    sn;

  assign accept = in_valid && !q_full;

  // Characters still allowed in the string, saturated at four.
  assign cap_lim = cfg.out_capacity - 16'd1;
  assign room16  = (cfg.out_capacity != 16'd0 && cap_lim > emitted_count) ?
                   cap_lim - emitted_count : 16'd0;
  assign room3   = (room16[15:2] != 14'd0) ? 3'd4 : {1'b0, room16[1:0]};

  assign fn        = (bytes_seen == 2'd0) ? 3'd1 : (bytes_seen == 2'd1) ? 3'd2 : 3'd3;
  assign acc_shift = {code_accum[14:0], in_byte[5:0]};
  assign mapped    = map_code(acc_shift);

  always_comb begin
    lead_byte_next    = lead_byte;
    cont0_next        = cont0;
    cont1_next        = cont1;
    bytes_needed_next = bytes_needed;
    bytes_seen_next   = bytes_seen;
    code_accum_next   = code_accum;
    cb       = '0;
    cn       = 3'd0;
    term     = 1'b0;
    do_fresh = 1'b0;
    pos      = 2'd0;

    if (end_of_text) begin
      if (bytes_needed != 2'd0) begin
        cb[0] = lead_byte;
        cb[1] = cont0;
        cb[2] = cont1;
        cn    = fn;
      end
      term              = (cfg.out_capacity != 16'd0);
      lead_byte_next    = 8'd0;
      cont0_next        = 8'd0;
      cont1_next        = 8'd0;
      bytes_needed_next = 2'd0;
      bytes_seen_next   = 2'd0;
      code_accum_next   = 21'd0;
    end else if (room3 != 3'd0) begin
      if (bytes_needed != 2'd0) begin
        if (in_byte[7:6] == 2'b10) begin
          if (({1'b0, bytes_seen} + 3'd1) >= {1'b0, bytes_needed}) begin
            lead_byte_next    = 8'd0;
            bytes_needed_next = 2'd0;
            bytes_seen_next   = 2'd0;
            code_accum_next   = 21'd0;
            if (mapped != 8'd0) begin
              cb[0] = mapped;
              cn    = 3'd1;
            end
          end else begin
            code_accum_next = acc_shift;
            if (bytes_seen == 2'd0) begin
              cont0_next = in_byte;
            end else if (bytes_seen == 2'd1) begin
              cont1_next = in_byte;
            end
            bytes_seen_next = bytes_seen + 2'd1;
          end
        end else begin
          // Broken sequence: pending bytes go out raw, then this byte starts over if room is left.
          cb[0] = lead_byte;
          cb[1] = cont0;
          cb[2] = cont1;
          cn    = fn;
          lead_byte_next    = 8'd0;
          bytes_needed_next = 2'd0;
          bytes_seen_next   = 2'd0;
          code_accum_next   = 21'd0;
          if (fn < room3) begin
            do_fresh = 1'b1;
            pos      = fn[1:0];
          end
        end
      end else begin
        do_fresh = 1'b1;
      end

      if (do_fresh) begin
        if (in_byte[7:5] == 3'b110) begin
          lead_byte_next    = in_byte;
          bytes_needed_next = 2'd1;
          bytes_seen_next   = 2'd0;
          code_accum_next   = {16'd0, in_byte[4:0]};
        end else if (in_byte[7:4] == 4'b1110) begin
          lead_byte_next    = in_byte;
          bytes_needed_next = 2'd2;
          bytes_seen_next   = 2'd0;
          code_accum_next   = {17'd0, in_byte[3:0]};
        end else if (in_byte[7:3] == 5'b11110) begin
          lead_byte_next    = in_byte;
          bytes_needed_next = 2'd3;
          bytes_seen_next   = 2'd0;
          code_accum_next   = {18'd0, in_byte[2:0]};
        end else begin
          cb[pos] = in_byte;
          cn      = {1'b0, pos} + 3'd1;
        end
      end
    end
  end

  // Capacity limit, then leading-space suppression and packing of what is left.
  always_comb begin
    na = (cn < room3) ? cn : room3;
    k  = 3'd0;
    sn = seen_nonspace;
    rec.chars = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < na) begin
        if (!(cb[i] == SPACE_CHAR && cfg.trim && !sn)) begin
          if (cb[i] != SPACE_CHAR) begin
            sn = 1'b1;
          end
          rec.chars[k[1:0]] = cb[i];
          k = k + 3'd1;
        end
      end
    end
    rec.nchar = k;
    rec.term  = term;
    emitted_count_next = end_of_text ? 16'd0 : emitted_count + {13'd0, na};
    seen_nonspace_next = end_of_text ? 1'b0 : sn;
  end

  assign push = accept && (k != 3'd0 || term);

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte     <= 8'd0;
      cont0         <= 8'd0;
      cont1         <= 8'd0;
      bytes_needed  <= 2'd0;
      bytes_seen    <= 2'd0;
      code_accum    <= 21'd0;
      emitted_count <= 16'd0;
      seen_nonspace <= 1'b0;
    end else if (accept) begin
      lead_byte     <= lead_byte_next;
      cont0         <= cont0_next;
      cont1         <= cont1_next;
      bytes_needed  <= bytes_needed_next;
      bytes_seen    <= bytes_seen_next;
      code_accum    <= code_accum_next;
      emitted_count <= emitted_count_next;
      seen_nonspace <= seen_nonspace_next;
    end
  end

endmodule

// File: rtl/core/u8dc_queue.sv
`timescale 1ns / 1ps

module u8dc_queue
  import u8dc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  u8dc_rec_t push_rec,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output u8dc_rec_t head
);

  u8dc_rec_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full   = (count == QCNT_W'(QDEPTH));
  assign empty  = (count == '0);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/u8dc_back.sv
`timescale 1ns / 1ps

module u8dc_back
  import u8dc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  u8dc_rec_t  head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_terminator,
  output logic       last
);

  logic [1:0]         idx;
  logic               load;
  logic [NCHAR_W-1:0] ntotal;
  logic               at_end;
  logic               at_char;

  assign load    = !empty && (!out_valid || !out_stall);
  assign ntotal  = head.nchar + NCHAR_W'(head.term);
  assign at_end  = (NCHAR_W'(idx) == ntotal - NCHAR_W'(1));
  assign at_char = (NCHAR_W'(idx) < head.nchar);
  assign pop     = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_end ? 2'd0 : idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= at_char ? head.chars[idx] : 8'd0;
      is_terminator <= !at_char;
      last          <= at_end;
    end
  end

endmodule

// File: rtl/core/utf8_to_display_charset.sv
`timescale 1ns / 1ps
// A word accepted by the front is written into the queue and then loaded into the output
// register, from which its first result can be taken.
// Throughput: one input word per cycle unless the queue is full; n results go out as n words.
// Up to four results per word; the four-entry queue absorbs short multi-result bursts.
// Reset (rst, synchronous, active high) clears the decoder state, the queue and the
// output register, and sets out_capacity to 64 and trim_leading_spaces to 0.

module utf8_to_display_charset
  import u8dc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_text,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 is_terminator,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers. Writes are always taken; an index past the
  // register list is accepted and ignored.
  u8dc_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_capacity <= CAPACITY_RESET;
      cfg.trim         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_OUT_CAPACITY) begin
        cfg.out_capacity <= cfg_data;
      end else if (cfg_index == CFG_TRIM_SPACES) begin
        cfg.trim <= cfg_data[0];
      end
    end
  end

  // The front decodes one UTF-8 word per cycle while the queue is not full,
  // applies the capacity limit and space trimming, and writes one record per
  // word that has results. The back drains each record one output word at a
  // time. The queue lets the front keep taking words while the back waits on the sink.
  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  u8dc_rec_t push_rec;
  u8dc_rec_t head;

  assign in_stall = q_full;

  u8dc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push),
    .rec         (push_rec)
  );

  u8dc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // The output register parts the queue from the sink, so a stalled
  // result never blocks the front directly.
  u8dc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .last          (last)
  );

endmodule

// File: rtl/core/u8dc_checker.sv
`timescale 1ns / 1ps

module u8dc_checker
  import u8dc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       is_terminator,
  input logic       last
);

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(is_terminator) && $stable(last))
    else $error("stalled result word changed");

  // The terminator carries a zero byte and closes its input word.
  a_term_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |-> out_byte == 8'd0 && last)
    else $error("malformed terminator word");

  // The input side only stalls when the queue is full, which means results are waiting.
  a_stall_backed: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Nothing is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("activity right after reset");

endmodule

bind utf8_to_display_charset u8dc_checker u_chk (.*);
